// ----- rtl/cte_pkg.sv -----
// Shared types and constants of the chained hash table engine.
// Used by the channel interfaces and every module under rtl/.
package cte_pkg;

  localparam int unsigned KEY_W      = 15;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned PROBE_W    = 7;
  localparam int unsigned BKT_W      = 5;
  localparam int unsigned BUCKETS_DEF  = 25;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Result selection chosen by the controller
  typedef enum logic [2:0] {
    RES_FULL     = 3'd0,
    RES_HEAD     = 3'd1,
    RES_FOUND    = 3'd2,
    RES_NF_HERE  = 3'd3,
    RES_NF_ALL   = 3'd4,
    RES_INS_HERE = 3'd5,
    RES_INS_END  = 3'd6
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     set_base;
    logic     scan_first;
    logic     scan_step;
    logic     set_res;
    res_sel_e res_sel;
    logic     sh_init;
    logic     sh_step;
    logic     place;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic op_search;
    logic mode;
    logic full;
    logic empty;
    logic eq;
    logic gt;
    logic last;
    logic mv_idle;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/cte_chan_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on cte_pkg for field widths.
interface cte_req_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [cte_pkg::KEY_W-1:0] key;
  modport source (output valid, operation, key, input ready);
  modport sink   (input valid, operation, key, output ready);
endinterface

interface cte_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cte_pkg::STATUS_W-1:0] status;
  logic [cte_pkg::POS_W-1:0]    position;
  logic [cte_pkg::PROBE_W-1:0]  probes;
  logic [cte_pkg::BKT_W-1:0]    bucket_index;
  modport source (output valid, status, position, probes, bucket_index, input ready);
  modport sink   (input valid, status, position, probes, bucket_index, output ready);
endinterface

// ----- rtl/cte_mod.sv -----
// Remainder of a key by the bucket count: reciprocal multiply, then subtract.
// Depends on cte_pkg.
module cte_mod #(
  parameter int unsigned BUCKETS = cte_pkg::BUCKETS_DEF,
  parameter int unsigned BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cte_pkg::KEY_W-1:0] key_i,
  output logic                      done_o,
  output logic [BW-1:0]             rem_o
);
  import cte_pkg::*;

  // Quotient by multiply with ceil(2^SH / BUCKETS); exact for every key width value
  localparam int unsigned SH    = KEY_W + $clog2(BUCKETS);
  localparam int unsigned MUL_W = KEY_W + 2;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);
  localparam logic [KEY_W-1:0] B_K   = KEY_W'(BUCKETS);

  logic [KEY_W+MUL_W-1:0] prod;
  logic [KEY_W-1:0]       key_q;
  logic [KEY_W-1:0]       quo_q, quo_d;
  logic [KEY_W-1:0]       rem_full;
  logic [BW-1:0]          rem_q;
  logic                   busy_q;

  // Estimate the quotient from the incoming key
  assign prod  = {{MUL_W{1'b0}}, key_i} * {{KEY_W{1'b0}}, RECIP};
  assign quo_d = KEY_W'(prod >> SH);

  // Subtract quotient times bucket count from the held key
  assign rem_full = key_q - quo_q * B_K;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      quo_q <= quo_d;
    end
    if (busy_q) begin
      rem_q <= rem_full[BW-1:0];
    end
  end

  assign done_o = !busy_q && !start_i;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/cte_ctrl.sv -----
// Controller state machine: sequences hashing, scan, shift and write-back.
// Depends on cte_pkg for the command and status structs.
module cte_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cte_pkg::sts_t sts_i,
  output cte_pkg::cmd_t cmd_o
);
  import cte_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_HASH   = 9'b000000010,
    S_BASE   = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_SHINIT = 9'b000100000,
    S_SHIFT  = 9'b001000000,
    S_PLACE  = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_FULL;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.mod_done) begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        cmd_o.set_base = 1'b1;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.op_search) begin
          if (sts_i.full) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_FULL;
            state_d       = S_FIN;
          end else if (!sts_i.mode || sts_i.empty) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_HEAD;
            state_d       = S_SHINIT;
          end else begin
            cmd_o.scan_first = 1'b1;
            state_d          = S_SCAN;
          end
        end else if (sts_i.empty) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_NF_ALL;
          state_d       = S_FIN;
        end else begin
          cmd_o.scan_first = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.op_search) begin
          if (sts_i.gt) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_INS_HERE;
            state_d       = S_SHINIT;
          end else if (sts_i.last) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_INS_END;
            state_d       = S_SHINIT;
          end else begin
            cmd_o.scan_step = 1'b1;
          end
        end else begin
          if (sts_i.eq) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_FOUND;
            state_d       = S_FIN;
          end else if (sts_i.mode && sts_i.gt) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_NF_HERE;
            state_d       = S_FIN;
          end else if (sts_i.last) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_NF_ALL;
            state_d       = S_FIN;
          end else begin
            cmd_o.scan_step = 1'b1;
          end
        end
      end
      S_SHINIT: begin
        cmd_o.sh_init = 1'b1;
        state_d       = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts_i.mv_idle) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.sh_step = 1'b1;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

endmodule

// ----- rtl/cte_datapath.sv -----
// Datapath: bucket key memory, fill counters, scan/shift counters, result
// and output registers. Depends on cte_pkg and cte_mod.
module cte_datapath #(
  parameter int unsigned BUCKETS  = cte_pkg::BUCKETS_DEF,
  parameter int unsigned CAPACITY = cte_pkg::CAPACITY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         req_operation_i,
  input  logic [cte_pkg::KEY_W-1:0]    req_key_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [cte_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [cte_pkg::POS_W-1:0]    rsp_position_o,
  output logic [cte_pkg::PROBE_W-1:0]  rsp_probes_o,
  output logic [cte_pkg::BKT_W-1:0]    rsp_bucket_index_o,
  input  cte_pkg::cmd_t                cmd_i,
  output cte_pkg::sts_t                sts_o
);
  import cte_pkg::*;

  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned IW    = $clog2(CAPACITY + 1);
  localparam int unsigned DEPTH = BUCKETS * CAPACITY;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] CAP_A = AW'(CAPACITY);
  localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata_q;
  logic [IW-1:0]    fill_q [BUCKETS];

  logic [KEY_W-1:0] key_q;
  logic             op_q;
  logic             mode_q;
  logic [BW-1:0]    bkt_q;
  logic [AW-1:0]    base_q;
  logic [IW-1:0]    i_q, r_q, mv_q, wr_idx_q;
  logic             rd_pend_q;
  status_e          res_status_q;
  logic [IW-1:0]    res_pos_q, res_probes_q;
  logic             out_valid_q;

  logic             mod_done;
  logic [BW-1:0]    mod_rem;
  logic [IW-1:0]    fcur, i_inc;
  logic             mem_we, mem_re;
  logic [IW-1:0]    widx, ridx;
  logic [KEY_W-1:0] wdata;

  cte_mod #(.BUCKETS(BUCKETS), .BW(BW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .key_i   (req_key_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign fcur  = fill_q[bkt_q];
  assign i_inc = i_q + 1'b1;

  // Memory port selection
  always_comb begin
    mem_we = 1'b0;
    widx   = res_pos_q;
    wdata  = key_q;
    if (cmd_i.sh_step && rd_pend_q) begin
      mem_we = 1'b1;
      widx   = wr_idx_q + 1'b1;
      wdata  = rdata_q;
    end else if (cmd_i.place) begin
      mem_we = 1'b1;
    end
    mem_re = 1'b0;
    ridx   = '0;
    if (cmd_i.scan_first) begin
      mem_re = 1'b1;
    end else if (cmd_i.scan_step && (i_inc < fcur)) begin
      mem_re = 1'b1;
      ridx   = i_inc;
    end else if (cmd_i.sh_step && (mv_q != '0)) begin
      mem_re = 1'b1;
      ridx   = r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[base_q + AW'(widx)] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[base_q + AW'(ridx)];
    end
  end

  // Fill counters and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) begin
        fill_q[b] <= '0;
      end
      mode_q      <= 1'b0;
      bkt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.set_base) begin
        bkt_q <= mod_rem;
      end
      if (cmd_i.place) begin
        fill_q[bkt_q] <= fcur + 1'b1;
      end
      if (cmd_i.sh_init) begin
        rd_pend_q <= 1'b0;
      end else if (cmd_i.sh_step) begin
        rd_pend_q <= (mv_q != '0);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operation registers, counters and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= req_key_i;
      op_q  <= req_operation_i;
    end
    if (cmd_i.set_base) begin
      base_q <= AW'(mod_rem) * CAP_A;
    end
    if (cmd_i.scan_first) begin
      i_q <= '0;
    end else if (cmd_i.scan_step) begin
      i_q <= i_inc;
    end
    if (cmd_i.sh_init) begin
      r_q  <= fcur - 1'b1;
      mv_q <= fcur - res_pos_q;
    end else if (cmd_i.sh_step && (mv_q != '0)) begin
      wr_idx_q <= r_q;
      r_q      <= r_q - 1'b1;
      mv_q     <= mv_q - 1'b1;
    end
    if (cmd_i.set_res) begin
      case (cmd_i.res_sel)
        RES_FULL: begin
          res_status_q <= ST_FULL;
          res_pos_q    <= '0;
          res_probes_q <= '0;
        end
        RES_HEAD: begin
          res_status_q <= ST_DONE;
          res_pos_q    <= '0;
          res_probes_q <= IW'(1);
        end
        RES_FOUND: begin
          res_status_q <= ST_DONE;
          res_pos_q    <= i_q;
          res_probes_q <= i_inc;
        end
        RES_NF_HERE: begin
          res_status_q <= ST_NOT_FOUND;
          res_pos_q    <= '0;
          res_probes_q <= i_inc;
        end
        RES_NF_ALL: begin
          res_status_q <= ST_NOT_FOUND;
          res_pos_q    <= '0;
          res_probes_q <= fcur;
        end
        RES_INS_HERE: begin
          res_status_q <= ST_DONE;
          res_pos_q    <= i_q;
          res_probes_q <= (i_q == '0) ? IW'(1) : i_q;
        end
        RES_INS_END: begin
          res_status_q <= ST_DONE;
          res_pos_q    <= fcur;
          res_probes_q <= fcur;
        end
        default: begin
          res_status_q <= ST_FULL;
          res_pos_q    <= '0;
          res_probes_q <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      rsp_status_o       <= res_status_q;
      rsp_position_o     <= POS_W'(res_pos_q);
      rsp_probes_o       <= PROBE_W'(res_probes_q);
      rsp_bucket_index_o <= BKT_W'(bkt_q);
    end
  end

  assign rsp_valid_o = out_valid_q;

  // Status toward the controller
  always_comb begin
    sts_o           = '0;
    sts_o.mod_done  = mod_done;
    sts_o.op_search = (op_q == OP_SEARCH);
    sts_o.mode      = mode_q;
    sts_o.full      = (fcur >= CAP_I);
    sts_o.empty     = (fcur == '0);
    sts_o.eq        = (rdata_q == key_q);
    sts_o.gt        = (rdata_q > key_q);
    sts_o.last      = (i_inc == fcur);
    sts_o.mv_idle   = (mv_q == '0) && !rd_pend_q;
    sts_o.out_free  = !out_valid_q || rsp_ready_i;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcur <= CAP_I) else $error("bucket fill above capacity");

  a_write_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (widx < CAP_I)) else $error("write beyond bucket row");

  a_place_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |-> (fcur < CAP_I)) else $error("place into full bucket");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("result overwritten before taken");

endmodule

// ----- rtl/chained_hash_table_engine.sv -----
// Top level of the chained hash table engine.
// Depends on cte_pkg, cte_chan_if, cte_ctrl and cte_datapath.
//
// Usage:
//   req_i carries one word per operation: operation (insert or search) and
//   key. rsp_o returns one word per operation: status, position, probes and
//   bucket_index. cfg_we_i/cfg_wdata_i write ordered_mode while idle.
// Sequence: the bucket hash (reciprocal multiply, then subtract), then
//   bucket selection and the decision, then the bucket entries are compared
//   in turn (search and ordered insert); an insert then sets up the shift,
//   moves the entries from its position onward up by one, places the key,
//   and finally the output register is loaded. A key dropped on a full
//   bucket goes to the output register straight after the decision.
// Throughput: one operation at a time; the next word is accepted in the cycle
//   after the previous result is loaded into the output register, so the
//   response side may hold its word while a new request is processed.
// Reset: all bucket fill counts clear at once and ordered_mode returns to
//   unordered; the key memory needs no clearing.
// Stall: a result not taken holds rsp_o; the engine finishes the next
//   operation and waits with it until the output register frees.
module chained_hash_table_engine #(
  parameter int unsigned BUCKETS  = cte_pkg::BUCKETS_DEF,
  parameter int unsigned CAPACITY = cte_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  cte_req_if.sink     req_i,
  cte_rsp_if.source   rsp_o
);
  import cte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cte_datapath #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .req_operation_i    (req_i.operation),
    .req_key_i          (req_i.key),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .rsp_status_o       (rsp_o.status),
    .rsp_position_o     (rsp_o.position),
    .rsp_probes_o       (rsp_o.probes),
    .rsp_bucket_index_o (rsp_o.bucket_index),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule
